@@ rtl/kts_pkg.sv @@
// Shared constants and types for the keyframe track sampler.
package kts_pkg;
   localparam int KTS_MAX_KEYS = 16;
   localparam int KTS_IDX_W    = 4;
   localparam int KTS_CNT_W    = 5;
   localparam int KTS_W_W      = 17;
   localparam logic [KTS_W_W-1:0] KTS_Q_ONE = 17'd65536;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [2:0] REG_KEY_COUNT  = 3'd0;
   localparam logic [2:0] REG_FOUR_COMP  = 3'd1;
   localparam logic [2:0] REG_ANIM_START = 3'd2;
   localparam logic [2:0] REG_ANIM_END   = 3'd3;
   localparam logic [2:0] REG_PLAY_SPEED = 3'd4;
   localparam logic [2:0] REG_LOOPING    = 3'd5;
   localparam logic [2:0] REG_PLAYING    = 3'd6;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;
endpackage

@@ rtl/keyframe_track_sampler_top.sv @@
// Top level of the keyframe track sampler: key table, sequencer, config registers.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   func, key_slot, key_time, val_*, delta_time
//   rsp      out        rsp_valid / rsp_stall   out_x..out_w, blend, left_key, right_key
//   csr      in/out     psel, penable, pready   paddr, pwrite, pwdata, prdata
//
// A write item is done on acceptance. A sample item runs accept, key scan (one
// table read a cycle), divider (one quotient bit a cycle), four blends through
// the shared multiplier, then the timer advance and finish; a stopped channel or
// a skipped sample leaves steps out.
// Reset (synchronous, active high) clears the timer, control state and registers;
// the key table is undefined until written.
// A waiting result does not block the next item; a finished item waits only
// when the output register still holds an untaken result.
module keyframe_track_sampler_top import kts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [3:0]           req_key_slot,
   input  logic signed [31:0]   req_key_time,
   input  logic signed [31:0]   req_val_x,
   input  logic signed [31:0]   req_val_y,
   input  logic signed [31:0]   req_val_z,
   input  logic signed [31:0]   req_val_w,
   input  logic [30:0]          req_delta_time,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z,
   output logic signed [31:0]   rsp_out_w,
   output logic [16:0]          rsp_blend,
   output logic [3:0]           rsp_left_key,
   output logic [3:0]           rsp_right_key,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_SEL, ST_DIV, ST_VL, ST_VR,
      ST_CMUL, ST_CACC, ST_SMUL, ST_TADV, ST_FIN
   } state_type;

   // configuration registers
   logic [4:0]         key_count_ff;
   logic               four_comp_ff;
   logic signed [31:0] anim_start_ff, anim_end_ff, play_speed_ff;
   logic               looping_ff, playing_ff;
   logic               cfg_we;
   logic [2:0]         cfg_idx;

   // key table
   logic [31:0]  key_times [KTS_MAX_KEYS];
   logic [127:0] key_vecs  [KTS_MAX_KEYS];
   logic [KTS_IDX_W-1:0] rd_addr;
   logic [31:0]  rd_time_ff;
   logic [127:0] rd_vec_ff;
   logic         tbl_we;

   // sequencer
   state_type            state_ff;
   logic signed [31:0]   timer_ff;
   logic [30:0]          delta_ff;
   logic [KTS_IDX_W-1:0] idx_ff, cmp_idx_ff;
   logic                 cmp_vld_ff;
   logic                 have_l_ff, have_r_ff, produce_ff;
   logic signed [31:0]   t_l_ff, t_r_ff;
   logic [KTS_IDX_W-1:0] i_l_ff, i_r_ff;
   logic [KTS_W_W-1:0]   w_ff;
   logic [127:0]         vl_ff;
   logic [1:0]           comp_ff;
   logic [31:0]          res_ff [4];
   logic [KTS_CNT_W-1:0] n_keys;
   logic                 req_acc, rsp_free;

   // output register
   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_w_ff;
   logic [16:0]          rsp_blend_ff;
   logic [3:0]           rsp_l_ff, rsp_r_ff;

   // shared units
   logic signed [32:0]   mul_a;
   logic signed [31:0]   mul_b;
   logic signed [64:0]   prod_ff;
   logic                 div_start;
   logic [31:0]          div_num, div_den;
   logic [KTS_W_W-1:0]   div_q;
   div_status_type       div_st;

   // scan compare and selection helpers
   logic signed [31:0]   t_cur;
   logic                 eff_have_r;
   logic [KTS_IDX_W-1:0] eff_i_r;
   logic signed [31:0]   eff_t_r;
   logic signed [31:0]   vl_c, vr_c;
   logic signed [48:0]   tsum;
   logic signed [31:0]   timer_base;

   assign pready  = 1'b1;
   assign cfg_idx = paddr[4:2];
   assign cfg_we  = psel && penable && pwrite;

   always_comb begin
      unique case (cfg_idx)
         REG_KEY_COUNT:  prdata = {27'd0, key_count_ff};
         REG_FOUR_COMP:  prdata = {31'd0, four_comp_ff};
         REG_ANIM_START: prdata = anim_start_ff;
         REG_ANIM_END:   prdata = anim_end_ff;
         REG_PLAY_SPEED: prdata = play_speed_ff;
         REG_LOOPING:    prdata = {31'd0, looping_ff};
         REG_PLAYING:    prdata = {31'd0, playing_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff  <= 5'd1;
         four_comp_ff  <= 1'b0;
         anim_start_ff <= '0;
         anim_end_ff   <= '0;
         play_speed_ff <= 32'sd65536;
         looping_ff    <= 1'b0;
         playing_ff    <= 1'b0;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            REG_KEY_COUNT:  key_count_ff  <= pwdata[4:0];
            REG_FOUR_COMP:  four_comp_ff  <= pwdata[0];
            REG_ANIM_START: anim_start_ff <= pwdata;
            REG_ANIM_END:   anim_end_ff   <= pwdata;
            REG_PLAY_SPEED: play_speed_ff <= pwdata;
            REG_LOOPING:    looping_ff    <= pwdata[0];
            REG_PLAYING:    playing_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign tbl_we    = req_acc && (req_func == FUNC_WRITE);

   // clamp the key count to the table depth
   assign n_keys = (key_count_ff > 5'(KTS_MAX_KEYS)) ? 5'(KTS_MAX_KEYS) : key_count_ff;

   // table port: scan index, then left key, then hold on right key
   always_comb begin
      unique case (state_ff)
         ST_SCAN: rd_addr = idx_ff;
         ST_VL:   rd_addr = i_l_ff;
         default: rd_addr = i_r_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         key_times[req_key_slot] <= req_key_time;
         key_vecs[req_key_slot]  <= {req_val_w, req_val_z, req_val_y, req_val_x};
      end
      rd_time_ff <= key_times[rd_addr];
      rd_vec_ff  <= key_vecs[rd_addr];
   end

   assign t_cur      = rd_time_ff;
   assign eff_have_r = have_r_ff;
   assign eff_i_r    = have_r_ff ? i_r_ff : i_l_ff;
   assign eff_t_r    = have_r_ff ? t_r_ff : t_l_ff;
   assign vl_c       = vl_ff[32*comp_ff +: 32];
   assign vr_c       = rd_vec_ff[32*comp_ff +: 32];

   // weight numerator and denominator, both nonnegative below 2^32
   assign div_start = (state_ff == ST_SEL) && have_l_ff && (i_l_ff != eff_i_r)
                      && (eff_t_r > t_l_ff);
   assign div_num   = 32'(33'(timer_ff) - 33'(t_l_ff));
   assign div_den   = 32'(33'(eff_t_r) - 33'(t_l_ff));

   // multiplier operands: component difference times weight, or speed times delta
   always_comb begin
      if (state_ff == ST_SMUL) begin
         mul_a = 33'(play_speed_ff);
         mul_b = {1'b0, delta_ff};
      end else begin
         mul_a = 33'(vr_c) - 33'(vl_c);
         mul_b = {15'd0, w_ff};
      end
   end

   assign timer_base = (looping_ff && (timer_ff > anim_end_ff)) ? anim_start_ff : timer_ff;
   // floor of the product over one, sign carried through
   assign tsum       = 49'(timer_ff) + $signed(prod_ff[64:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timer_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         have_l_ff    <= 1'b0;
         have_r_ff    <= 1'b0;
         produce_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished result, or drop the one just taken
         if (state_ff == ST_FIN && produce_ff && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // fold the key read last cycle into the bracket
         if (cmp_vld_ff) begin
            if (t_cur <= timer_ff && (!have_l_ff || t_cur > t_l_ff)) begin
               t_l_ff    <= t_cur;
               i_l_ff    <= cmp_idx_ff;
               have_l_ff <= 1'b1;
            end
            if (t_cur >= timer_ff && (!have_r_ff || t_cur < t_r_ff)) begin
               t_r_ff    <= t_cur;
               i_r_ff    <= cmp_idx_ff;
               have_r_ff <= 1'b1;
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_func == FUNC_SAMPLE && playing_ff) begin
                  delta_ff   <= req_delta_time;
                  have_l_ff  <= 1'b0;
                  have_r_ff  <= 1'b0;
                  produce_ff <= 1'b0;
                  idx_ff     <= '0;
                  state_ff   <= (n_keys == '0) ? ST_SMUL : ST_SCAN;
               end
            end
            ST_SCAN: begin
               cmp_vld_ff <= 1'b1;
               cmp_idx_ff <= idx_ff;
               idx_ff     <= idx_ff + 1'b1;
               if ({1'b0, idx_ff} == n_keys - 5'd1) begin
                  state_ff <= ST_SCAN_LAST;
               end
            end
            ST_SCAN_LAST: begin
               cmp_vld_ff <= 1'b0;
               state_ff   <= ST_SEL;
            end
            ST_SEL: begin
               if (!have_l_ff) begin
                  state_ff <= ST_SMUL;
               end else begin
                  produce_ff <= 1'b1;
                  i_r_ff     <= eff_i_r;
                  t_r_ff     <= eff_t_r;
                  have_r_ff  <= eff_have_r;
                  w_ff       <= '0;
                  state_ff   <= div_start ? ST_DIV : ST_VL;
               end
            end
            ST_DIV: begin
               if (div_st.done) begin
                  w_ff     <= div_q;
                  state_ff <= ST_VL;
               end
            end
            ST_VL: begin
               state_ff <= ST_VR;
            end
            ST_VR: begin
               comp_ff  <= '0;
               state_ff <= ST_CMUL;
            end
            ST_CMUL: begin
               state_ff <= ST_CACC;
            end
            ST_CACC: begin
               // add the scaled difference back onto the left value; the fourth is zero unless four_comp is set
               if (comp_ff == 2'd3 && !four_comp_ff) begin
                  res_ff[comp_ff] <= '0;
               end else begin
                  res_ff[comp_ff] <= vl_c + prod_ff[47:16];
               end
               comp_ff  <= comp_ff + 2'd1;
               state_ff <= (comp_ff == 2'd3) ? ST_SMUL : ST_CMUL;
            end
            ST_SMUL: begin
               timer_ff <= timer_base;
               state_ff <= ST_TADV;
            end
            ST_TADV: begin
               if (tsum > 49'sd2147483647) begin
                  timer_ff <= 32'sh7FFFFFFF;
               end else if (tsum < -49'sd2147483648) begin
                  timer_ff <= 32'sh80000000;
               end else begin
                  timer_ff <= tsum[31:0];
               end
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!produce_ff) begin
                  state_ff <= ST_IDLE;
               end else if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // latch the left vector while the right one is being read
   always_ff @(posedge clock) begin
      if (state_ff == ST_VR) begin
         vl_ff <= rd_vec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && produce_ff && rsp_free) begin
         rsp_x_ff     <= res_ff[0];
         rsp_y_ff     <= res_ff[1];
         rsp_z_ff     <= res_ff[2];
         rsp_w_ff     <= res_ff[3];
         rsp_blend_ff <= w_ff;
         rsp_l_ff     <= i_l_ff;
         rsp_r_ff     <= i_r_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_out_w     = rsp_w_ff;
   assign rsp_blend     = rsp_blend_ff;
   assign rsp_left_key  = rsp_l_ff;
   assign rsp_right_key = rsp_r_ff;

   kts_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   kts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (div_den),
      .quot_ff (div_q),
      .status  (div_st)
   );

`ifndef SYNTHESIS
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CACC |-> $past(state_ff) == ST_CMUL)
      else $error("blend accumulate without multiply");
   a_blend_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_blend_ff <= KTS_Q_ONE)
      else $error("blend weight above one");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide step");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result loaded outside finish step");
`endif
endmodule

@@ rtl/kts_mul.sv @@
// Shared signed multiplier with registered product.
module kts_mul import kts_pkg::*; (
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [64:0] prod_ff
);
   logic signed [64:0] prod_in;

   assign prod_in = 65'(op_a) * 65'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

@@ rtl/kts_div.sv @@
// Radix-2 restoring divider for the blend weight, one quotient bit per cycle.
module kts_div import kts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        num,
   input  logic [31:0]        den,
   output logic [KTS_W_W-1:0] quot_ff,
   output div_status_type     status
);
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        lsb_ff, lsb_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [KTS_W_W-1:0] quot_in;
   logic [32:0] trial;
   logic [32:0] diff;

   always_comb begin
      trial   = {rem_ff, lsb_ff};
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      lsb_in  = lsb_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      if (start) begin
         rem_in  = {1'b0, num[31:1]};
         lsb_in  = num[0];
         den_in  = den;
         cnt_in  = 5'(KTS_W_W);
         busy_in = 1'b1;
         quot_in = '0;
      end else if (busy_ff) begin
         lsb_in = 1'b0;
         if (!diff[32]) begin
            rem_in  = diff[31:0];
            quot_in = {quot_ff[KTS_W_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[31:0];
            quot_in = {quot_ff[KTS_W_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      lsb_ff  <= lsb_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule
